// File: rtl/core/kh8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kh8_pkg
// Shared widths, codes and helpers of the compensated histogram accumulator.
// ----------------------------------------------------------------------------
package kh8_pkg;

   localparam int NUM_DIMS      = 8;
   localparam int DIM_W         = 3;
   localparam int SIZE_W        = 13;
   localparam int INDEX_W       = 12;
   localparam int FLAT_W        = 12;
   localparam int QTY_W         = 32;
   localparam int DBL_W         = 64;
   localparam int BIN_DEPTH_DEF = 4096;
   localparam int PADDR_W       = 5;
   localparam int PDATA_W       = 32;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [DBL_W-1:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [DBL_W-1:0] DBL_QUIET_BIT   = 64'h0008_0000_0000_0000;

   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [DBL_W-1:0]   dbl_type;

endpackage : kh8_pkg
`default_nettype wire

// File: rtl/core/kh8_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kh8_req_if
// Request channel: operation, single-precision quantity and eight indices.
// ----------------------------------------------------------------------------
interface kh8_req_if import kh8_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      op;
   logic [QTY_W-1:0] quantity;
   index_type index0;
   index_type index1;
   index_type index2;
   index_type index3;
   index_type index4;
   index_type index5;
   index_type index6;
   index_type index7;

   modport source (output valid, op, quantity, index0, index1, index2, index3,
                   index4, index5, index6, index7, input ready);
   modport sink   (input valid, op, quantity, index0, index1, index2, index3,
                   index4, index5, index6, index7, output ready);
endinterface : kh8_req_if
`default_nettype wire

// File: rtl/core/kh8_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kh8_rsp_if
// Response channel: flat bin index, bin sum and range flag.
// ----------------------------------------------------------------------------
interface kh8_rsp_if import kh8_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FLAT_W-1:0] flat_index;
   dbl_type           bin_total;
   logic              out_of_range;

   modport source (output valid, flat_index, bin_total, out_of_range, input ready);
   modport sink   (input valid, flat_index, bin_total, out_of_range, output ready);
endinterface : kh8_rsp_if
`default_nettype wire

// File: rtl/core/kh8_fadd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kh8_fadd
// Four-stage double-precision adder/subtractor, round to nearest even.
// ----------------------------------------------------------------------------
module kh8_fadd import kh8_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire dbl_type op_a,
   input  wire dbl_type op_b,
   input  wire logic    subtract,
   output logic         out_valid,
   output dbl_type      result
);

   localparam int MW = 56;

   function automatic logic [5:0] count_lz(input logic [MW-1:0] v);
      logic [5:0] n;
      logic       hit;
      n = '0;
      hit = 1'b0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (!hit) begin
            if (v[i]) hit = 1'b1;
            else n = n + 6'd1;
         end
      end
      return n;
   endfunction

   // stage 1: unpack, order, align
   logic          a_nan, b_nan, a_inf, b_inf, sb_eff, swap;
   logic          xs, ys;
   logic [10:0]   xf, yf, xe, ye, de;
   logic [51:0]   xfr, yfr;
   logic [MW-1:0] xm, ym, ysh;
   logic          sticky;
   logic          spec;
   dbl_type       spec_val;

   always_comb begin
      a_nan  = (op_a[62:52] == 11'h7FF) && (op_a[51:0] != '0);
      b_nan  = (op_b[62:52] == 11'h7FF) && (op_b[51:0] != '0);
      a_inf  = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == '0);
      b_inf  = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == '0);
      sb_eff = op_b[63] ^ subtract;
      swap   = op_b[62:0] > op_a[62:0];
      xs     = swap ? sb_eff : op_a[63];
      ys     = swap ? op_a[63] : sb_eff;
      xf     = swap ? op_b[62:52] : op_a[62:52];
      yf     = swap ? op_a[62:52] : op_b[62:52];
      xfr    = swap ? op_b[51:0] : op_a[51:0];
      yfr    = swap ? op_a[51:0] : op_b[51:0];
      xe     = (xf == '0) ? 11'd1 : xf;
      ye     = (yf == '0) ? 11'd1 : yf;
      de     = xe - ye;
      xm     = {(xf != '0), xfr, 3'b000};
      ym     = {(yf != '0), yfr, 3'b000};
      if (de >= 11'(MW)) begin
         ysh    = '0;
         sticky = |ym;
      end else begin
         ysh    = ym >> de;
         sticky = |(ym & ~({MW{1'b1}} << de));
      end
      ysh[0] = ysh[0] | sticky;
      spec     = 1'b1;
      spec_val = '0;
      if (a_nan) spec_val = op_a | DBL_QUIET_BIT;
      else if (b_nan) spec_val = op_b | DBL_QUIET_BIT;
      else if (a_inf && b_inf) spec_val = (op_a[63] != sb_eff) ? DBL_DEFAULT_NAN : op_a;
      else if (a_inf) spec_val = op_a;
      else if (b_inf) spec_val = {sb_eff, op_b[62:0]};
      else spec = 1'b0;
   end

   logic          p1_valid_ff, p2_valid_ff, p3_valid_ff, out_valid_ff;
   logic          p1_sign_ff, p1_sub_ff, p1_zs_ff, p1_spec_ff;
   logic [10:0]   p1_exp_ff;
   logic [MW-1:0] p1_xm_ff, p1_ym_ff;
   dbl_type       p1_sv_ff;

   logic          p2_sign_ff, p2_zs_ff, p2_spec_ff;
   logic [10:0]   p2_exp_ff;
   logic [MW:0]   p2_sum_ff;
   dbl_type       p2_sv_ff;

   logic          p3_sign_ff, p3_zs_ff, p3_spec_ff;
   logic [10:0]   p3_exp_ff;
   logic [MW:0]   p3_sum_ff;
   logic [5:0]    p3_lz_ff;
   dbl_type       p3_sv_ff;

   dbl_type       result_ff;

   logic [10:0]   shamt;
   logic [MW-1:0] nm;
   logic [11:0]   ne, fe;
   logic          rup;
   logic [53:0]   rm;
   logic [51:0]   ff;
   dbl_type       result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= in_valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         out_valid_ff <= p3_valid_ff;
      end
   end

   // stage 2: magnitude add or subtract
   always_ff @(posedge clock) begin
      p1_sign_ff <= xs;
      p1_sub_ff  <= xs != ys;
      p1_zs_ff   <= (xs == ys) ? xs : 1'b0;
      p1_spec_ff <= spec;
      p1_sv_ff   <= spec_val;
      p1_exp_ff  <= xe;
      p1_xm_ff   <= xm;
      p1_ym_ff   <= ysh;

      p2_sign_ff <= p1_sign_ff;
      p2_zs_ff   <= p1_zs_ff;
      p2_spec_ff <= p1_spec_ff;
      p2_sv_ff   <= p1_sv_ff;
      p2_exp_ff  <= p1_exp_ff;
      p2_sum_ff  <= p1_sub_ff ? ({1'b0, p1_xm_ff} - {1'b0, p1_ym_ff})
                              : ({1'b0, p1_xm_ff} + {1'b0, p1_ym_ff});

      p3_sign_ff <= p2_sign_ff;
      p3_zs_ff   <= p2_zs_ff;
      p3_spec_ff <= p2_spec_ff;
      p3_sv_ff   <= p2_sv_ff;
      p3_exp_ff  <= p2_exp_ff;
      p3_sum_ff  <= p2_sum_ff;
      p3_lz_ff   <= count_lz(p2_sum_ff[MW-1:0]);

      result_ff  <= result_in;
   end

   // stage 4: normalize and round
   always_comb begin
      shamt = '0;
      if (p3_sum_ff[MW]) begin
         nm    = p3_sum_ff[MW:1];
         nm[0] = nm[0] | p3_sum_ff[0];
         ne    = {1'b0, p3_exp_ff} + 12'd1;
      end else begin
         shamt = ({5'b0, p3_lz_ff} > (p3_exp_ff - 11'd1)) ? (p3_exp_ff - 11'd1)
                                                          : {5'b0, p3_lz_ff};
         nm    = p3_sum_ff[MW-1:0] << shamt;
         ne    = {1'b0, p3_exp_ff - shamt};
         if (!nm[MW-1]) ne = '0;
      end
      rup = nm[2] && (nm[1] || nm[0] || nm[3]);
      rm  = {1'b0, nm[MW-1:3]} + 54'(rup);
      if (rm[53]) begin
         fe = ne + 12'd1;
         ff = rm[52:1];
      end else if (ne == '0) begin
         fe = {11'b0, rm[52]};
         ff = rm[51:0];
      end else begin
         fe = ne;
         ff = rm[51:0];
      end
      if (fe >= 12'd2047) begin
         fe = 12'd2047;
         ff = '0;
      end
      if (p3_spec_ff) result_in = p3_sv_ff;
      else if (p3_sum_ff == '0) result_in = {p3_zs_ff, 63'b0};
      else result_in = {p3_sign_ff, fe[10:0], ff};
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule : kh8_fadd
`default_nettype wire

// File: rtl/core/kahan_histogram_8d_accumulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kahan_histogram_8d_accumulator_unit
// Eight-dimensional histogram with Kahan-compensated double bin sums.
// ----------------------------------------------------------------------------
// One item at a time from request beat to response beat; an out-of-range
// request skips the bin read and the adds. The index walk runs on one shared
// multiplier; the four dependent double adds each issue and then pass the
// four stages of one shared adder.
// Reset: after reset the unit sweeps both bin memories to +0.0 with req not
// ready; size registers reset to 1.
module kahan_histogram_8d_accumulator_unit import kh8_pkg::*; #(
   parameter int BIN_DEPTH = BIN_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   kh8_req_if.sink                 req_chan,
   kh8_rsp_if.source               rsp_chan,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int PW = AW + SIZE_W + 1;
   localparam logic [AW-1:0] LAST_BIN = AW'(BIN_DEPTH - 1);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_LOC   = 4'd2;
   localparam logic [3:0] ST_READ  = 4'd3;
   localparam logic [3:0] ST_FETCH = 4'd4;
   localparam logic [3:0] ST_ISSUE = 4'd5;
   localparam logic [3:0] ST_WAIT  = 4'd6;
   localparam logic [3:0] ST_WRITE = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   localparam logic [1:0] PH_Y    = 2'd0;
   localparam logic [1:0] PH_T    = 2'd1;
   localparam logic [1:0] PH_DIFF = 2'd2;
   localparam logic [1:0] PH_COMP = 2'd3;

   function automatic dbl_type widen_single(input logic [QTY_W-1:0] w);
      logic [7:0]  e;
      logic [22:0] f, fn;
      logic [4:0]  lz;
      logic        hit;
      dbl_type     r;
      e   = w[30:23];
      f   = w[22:0];
      lz  = '0;
      hit = 1'b0;
      for (int i = 22; i >= 0; i--) begin
         if (!hit) begin
            if (f[i]) hit = 1'b1;
            else lz = lz + 5'd1;
         end
      end
      fn = f << (lz + 5'd1);
      if (e == 8'hFF) r = {w[31], 11'h7FF, f, 29'b0} | ((f != '0) ? DBL_QUIET_BIT : '0);
      else if (e == '0 && f == '0) r = {w[31], 63'b0};
      else if (e == '0) r = {w[31], 11'd896 - 11'(lz), fn, 29'b0};
      else r = {w[31], 11'(e) + 11'd896, f, 29'b0};
      return r;
   endfunction

   // configuration
   size_type size_ff [NUM_DIMS];
   logic [DIM_W-1:0] csr_idx;

   assign csr_idx = paddr[DIM_W+1:2];
   assign pready  = 1'b1;
   assign prdata  = PDATA_W'(size_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIMS; i++) size_ff[i] <= size_type'(1);
      end else if (psel && penable && pwrite && pready) begin
         size_ff[csr_idx] <= pwdata[SIZE_W-1:0];
      end
   end

   // sequencer
   logic [3:0]       state_ff, state_in;
   logic [DIM_W-1:0] dim_ff, dim_in;
   logic [1:0]       ph_ff, ph_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             op_ff;
   logic [QTY_W-1:0] qty_ff;
   index_type        idx_ff [NUM_DIMS];
   logic [AW-1:0]    acc_ff;
   dbl_type          qd_ff, s_ff, c_ff, y_ff, t_ff, d_ff, cn_ff;
   dbl_type          sum_rd_ff, comp_rd_ff;
   logic [FLAT_W-1:0] res_flat_ff, rsp_flat_ff;
   dbl_type          res_total_ff, rsp_total_ff;
   logic             res_oor_ff, rsp_oor_ff;

   dbl_type sum_mem  [BIN_DEPTH];
   dbl_type comp_mem [BIN_DEPTH];

   logic [PW-1:0] horner;
   logic          loc_bad;
   logic          accept_req, rsp_free;
   logic          add_go, add_done;
   dbl_type       add_a, add_b, add_res;
   logic          add_sub;

   assign horner = PW'(acc_ff) * PW'(size_ff[dim_ff]) + PW'(idx_ff[dim_ff]);
   assign loc_bad = ({1'b0, idx_ff[dim_ff]} >= size_ff[dim_ff]) ||
                    (horner >= PW'(BIN_DEPTH));
   assign accept_req = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign add_go     = state_ff == ST_ISSUE;

   always_comb begin
      add_a   = qd_ff;
      add_b   = c_ff;
      add_sub = 1'b1;
      case (ph_ff)
         PH_Y: begin
            add_a   = qd_ff;
            add_b   = c_ff;
            add_sub = 1'b1;
         end
         PH_T: begin
            add_a   = s_ff;
            add_b   = y_ff;
            add_sub = 1'b0;
         end
         PH_DIFF: begin
            add_a   = t_ff;
            add_b   = s_ff;
            add_sub = 1'b1;
         end
         PH_COMP: begin
            add_a   = d_ff;
            add_b   = y_ff;
            add_sub = 1'b1;
         end
         default: begin
            add_a   = qd_ff;
            add_b   = c_ff;
            add_sub = 1'b1;
         end
      endcase
   end

   kh8_fadd u_fadd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (add_go),
      .op_a      (add_a),
      .op_b      (add_b),
      .subtract  (add_sub),
      .out_valid (add_done),
      .result    (add_res)
   );

   always_comb begin
      state_in     = state_ff;
      dim_in       = dim_ff;
      ph_in        = ph_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_BIN) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            dim_in = '0;
            if (accept_req) state_in = ST_LOC;
         end
         ST_LOC: begin
            dim_in = dim_ff + DIM_W'(1);
            if (loc_bad) state_in = ST_DONE;
            else if (dim_ff == DIM_W'(NUM_DIMS - 1)) state_in = ST_READ;
         end
         ST_READ: state_in = ST_FETCH;
         ST_FETCH: begin
            ph_in = PH_Y;
            state_in = (op_ff == OP_READ) ? ST_DONE : ST_ISSUE;
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (add_done) begin
               ph_in = ph_ff + 2'd1;
               state_in = (ph_ff == PH_COMP) ? ST_WRITE : ST_ISSUE;
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         dim_ff       <= '0;
         ph_ff        <= PH_Y;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         ph_ff        <= ph_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      qd_ff <= widen_single(qty_ff);
      if (accept_req) begin
         op_ff     <= req_chan.op;
         qty_ff    <= req_chan.quantity;
         idx_ff[0] <= req_chan.index0;
         idx_ff[1] <= req_chan.index1;
         idx_ff[2] <= req_chan.index2;
         idx_ff[3] <= req_chan.index3;
         idx_ff[4] <= req_chan.index4;
         idx_ff[5] <= req_chan.index5;
         idx_ff[6] <= req_chan.index6;
         idx_ff[7] <= req_chan.index7;
         acc_ff    <= '0;
      end
      if (state_ff == ST_LOC) begin
         acc_ff <= AW'(horner);
         if (loc_bad) begin
            res_flat_ff  <= '0;
            res_total_ff <= '0;
            res_oor_ff   <= 1'b1;
         end
      end
      if (state_ff == ST_FETCH) begin
         s_ff         <= sum_rd_ff;
         c_ff         <= comp_rd_ff;
         res_flat_ff  <= FLAT_W'(acc_ff);
         res_total_ff <= sum_rd_ff;
         res_oor_ff   <= 1'b0;
      end
      if (state_ff == ST_WAIT && add_done) begin
         case (ph_ff)
            PH_Y:    y_ff  <= add_res;
            PH_T:    t_ff  <= add_res;
            PH_DIFF: d_ff  <= add_res;
            PH_COMP: cn_ff <= add_res;
            default: y_ff  <= add_res;
         endcase
      end
      if (state_ff == ST_WRITE) res_total_ff <= t_ff;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_flat_ff  <= res_flat_ff;
         rsp_total_ff <= res_total_ff;
         rsp_oor_ff   <= res_oor_ff;
      end
   end

   // bin memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         sum_mem[clr_ff]  <= '0;
         comp_mem[clr_ff] <= '0;
      end else if (state_ff == ST_WRITE) begin
         sum_mem[acc_ff]  <= t_ff;
         comp_mem[acc_ff] <= cn_ff;
      end
      sum_rd_ff  <= sum_mem[acc_ff];
      comp_rd_ff <= comp_mem[acc_ff];
   end

   assign req_chan.ready        = state_ff == ST_IDLE;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.flat_index   = rsp_flat_ff;
   assign rsp_chan.bin_total    = rsp_total_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

endmodule : kahan_histogram_8d_accumulator_unit
`default_nettype wire
